### hw/rtl/ehns_pkg.sv
// types and constants shared by the ecmp hash next-hop select block
// no dependencies

package ehns_pkg;

    localparam int HASH_W      = 32;
    localparam int GSIZE_W     = 5;
    localparam int MEMBER_W    = 4;
    localparam int PROTO_W     = 8;
    localparam int PORT_W      = 16;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_QP_MODE   = 1'b1;

    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'h06;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'h11;
    localparam logic [PROTO_W-1:0] PROTO_ACK  = 8'hfc;
    localparam logic [PROTO_W-1:0] PROTO_NACK = 8'hfd;

    localparam logic [HASH_W-1:0] MH_C1 = 32'hcc9e2d51;
    localparam logic [HASH_W-1:0] MH_C2 = 32'h1b873593;
    localparam logic [HASH_W-1:0] MH_N  = 32'he6546b64;
    localparam logic [HASH_W-1:0] MH_F1 = 32'h85ebca6b;
    localparam logic [HASH_W-1:0] MH_F2 = 32'hc2b2ae35;

    localparam logic [HASH_W-1:0] LEN_QP   = 32'd4;
    localparam logic [HASH_W-1:0] LEN_FLOW = 32'd12;

    typedef struct packed {
        logic [2:0][HASH_W-1:0] w;
        logic                   qp;
        logic [GSIZE_W-1:0]     gsize;
    } key_t;

    typedef struct packed {
        logic [HASH_W-1:0]  h;
        logic               qp;
        logic [GSIZE_W-1:0] gsize;
    } hash_t;

    typedef struct packed {
        logic [MEMBER_W-1:0] member_index;
        logic [HASH_W-1:0]   hash_value;
    } res_t;

endpackage

### hw/rtl/ecmp_hash_next_hop_select.sv
// ECMP next-hop select: seeded 32-bit MurmurHash3 over the flow tuple (source
// address, destination address, port word) or over the queue-pair id, and the
// member index hash mod group size. Takes one item per clock while the output
// is not stalled; each item passes five key-mixing stages, three finalizer
// stages and four remainder stages of eight hash bits each. Every stage holds
// its item under backpressure and bubbles close up, so the input keeps accepting
// while any stage is empty. Group size is clamped to min(MAX_NEXT_HOPS, 31);
// a group size of zero gives member index zero. Write configuration only while
// the pipeline is empty. Uses ehns_pkg, ehns_mix, ehns_fin, ehns_mod.

module ecmp_hash_next_hop_select #(
    parameter int MAX_NEXT_HOPS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // source_ip, destination_ip, protocol, source_port, destination_port,
    // queue_pair_id, group_size
    input  logic [ehns_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // hash_value, member_index
    output logic [ehns_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [ehns_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ehns_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [ehns_pkg::HASH_W-1:0]  hash_seed_reg;
    logic                         qp_mode_reg;

    logic [ehns_pkg::HASH_W-1:0]  source_ip;
    logic [ehns_pkg::HASH_W-1:0]  destination_ip;
    logic [ehns_pkg::PROTO_W-1:0] protocol;
    logic [ehns_pkg::PORT_W-1:0]  source_port;
    logic [ehns_pkg::PORT_W-1:0]  destination_port;
    logic [ehns_pkg::HASH_W-1:0]  queue_pair_id;
    logic [ehns_pkg::GSIZE_W-1:0] group_size;
    logic                         has_ports;
    logic [ehns_pkg::HASH_W-1:0]  port_word;

    ehns_pkg::key_t  key;
    ehns_pkg::hash_t mix_data;
    ehns_pkg::hash_t fin_data;
    ehns_pkg::res_t  res;
    logic            mix_valid;
    logic            mix_ready;
    logic            fin_valid;
    logic            fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_seed_reg <= '0;
            qp_mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ehns_pkg::REG_HASH_SEED: hash_seed_reg <= cfg_data;
                ehns_pkg::REG_QP_MODE:   qp_mode_reg   <= cfg_data[0];
            endcase
        end
    end

    assign source_ip        = s_axis_tdata[31:0];
    assign destination_ip   = s_axis_tdata[63:32];
    assign protocol         = s_axis_tdata[71:64];
    assign source_port      = s_axis_tdata[87:72];
    assign destination_port = s_axis_tdata[103:88];
    assign queue_pair_id    = s_axis_tdata[135:104];
    assign group_size       = s_axis_tdata[140:136];

    // ports enter the key only for tcp, udp, ack and nack
    assign has_ports = (protocol == ehns_pkg::PROTO_TCP) || (protocol == ehns_pkg::PROTO_UDP)
                    || (protocol == ehns_pkg::PROTO_ACK) || (protocol == ehns_pkg::PROTO_NACK);
    assign port_word = has_ports ? {destination_port, source_port} : '0;

    assign key.w[0]  = qp_mode_reg ? queue_pair_id : source_ip;
    assign key.w[1]  = destination_ip;
    assign key.w[2]  = port_word;
    assign key.qp    = qp_mode_reg;
    assign key.gsize = group_size;

    ehns_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .seed      (hash_seed_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (key),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_data  (mix_data)
    );

    ehns_fin u_fin (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_data   (mix_data),
        .out_valid (fin_valid),
        .out_ready (fin_ready),
        .out_data  (fin_data)
    );

    ehns_mod #(
        .MAX_NEXT_HOPS (MAX_NEXT_HOPS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fin_valid),
        .in_ready  (fin_ready),
        .in_data   (fin_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res)
    );

    assign m_axis_tdata = {4'b0000, res.member_index, res.hash_value};

endmodule

### hw/rtl/ehns_mix.sv
// five-stage murmur3 key mixing: key word premix in three lanes, then the
// serial hash update one word per stage (qp mode: first word only); uses ehns_pkg

module ehns_mix (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ehns_pkg::HASH_W-1:0] seed,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ehns_pkg::key_t              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ehns_pkg::hash_t             out_data
);

    localparam int STG = 5;

    typedef struct packed {
        logic [ehns_pkg::HASH_W-1:0]       h;
        logic [2:0][ehns_pkg::HASH_W-1:0]  k;
        logic                              qp;
        logic [ehns_pkg::GSIZE_W-1:0]      gsize;
    } mix_t;

    function automatic logic [ehns_pkg::HASH_W-1:0] mh_round(
        input logic [ehns_pkg::HASH_W-1:0] h,
        input logic [ehns_pkg::HASH_W-1:0] k
    );
        logic [ehns_pkg::HASH_W-1:0] x;
        x = h ^ k;
        x = {x[18:0], x[31:19]};
        return {x[29:0], 2'b00} + x + ehns_pkg::MH_N;
    endfunction

    logic [STG-1:0] valid_reg;
    logic [STG:0]   adv;
    mix_t           s_reg [STG];

    always_comb
    begin
        adv[STG] = out_ready;
        for (int i = STG - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STG-1];
    assign out_data  = '{h: s_reg[STG-1].h, qp: s_reg[STG-1].qp,
                         gsize: s_reg[STG-1].gsize};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STG; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s_reg[0].h     <= '0;
            s_reg[0].qp    <= in_data.qp;
            s_reg[0].gsize <= in_data.gsize;
            for (int j = 0; j < 3; j++)
            begin
                s_reg[0].k[j] <= in_data.w[j] * ehns_pkg::MH_C1;
            end
        end
        if (adv[1])
        begin
            s_reg[1].h     <= s_reg[0].h;
            s_reg[1].qp    <= s_reg[0].qp;
            s_reg[1].gsize <= s_reg[0].gsize;
            for (int j = 0; j < 3; j++)
            begin
                s_reg[1].k[j] <= {s_reg[0].k[j][16:0], s_reg[0].k[j][31:17]}
                                 * ehns_pkg::MH_C2;
            end
        end
        if (adv[2])
        begin
            s_reg[2].k     <= s_reg[1].k;
            s_reg[2].qp    <= s_reg[1].qp;
            s_reg[2].gsize <= s_reg[1].gsize;
            s_reg[2].h     <= mh_round(seed, s_reg[1].k[0]);
        end
        if (adv[3])
        begin
            s_reg[3].k     <= s_reg[2].k;
            s_reg[3].qp    <= s_reg[2].qp;
            s_reg[3].gsize <= s_reg[2].gsize;
            s_reg[3].h     <= s_reg[2].qp ? s_reg[2].h : mh_round(s_reg[2].h, s_reg[2].k[1]);
        end
        if (adv[4])
        begin
            s_reg[4].k     <= s_reg[3].k;
            s_reg[4].qp    <= s_reg[3].qp;
            s_reg[4].gsize <= s_reg[3].gsize;
            s_reg[4].h     <= s_reg[3].qp ? s_reg[3].h : mh_round(s_reg[3].h, s_reg[3].k[2]);
        end
    end

endmodule

### hw/rtl/ehns_fin.sv
// three-stage murmur3 finalizer: length fold and two avalanche multiplies
// uses ehns_pkg

module ehns_fin (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ehns_pkg::hash_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ehns_pkg::hash_t out_data
);

    localparam int STG = 3;

    logic [STG-1:0]              valid_reg;
    logic [STG:0]                adv;
    ehns_pkg::hash_t             s_reg [STG];
    logic [ehns_pkg::HASH_W-1:0] x0;
    logic [ehns_pkg::HASH_W-1:0] x1;

    always_comb
    begin
        adv[STG] = out_ready;
        for (int i = STG - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        x0 = in_data.h ^ (in_data.qp ? ehns_pkg::LEN_QP : ehns_pkg::LEN_FLOW);
        x0 = x0 ^ (x0 >> 16);
        x1 = s_reg[0].h ^ (s_reg[0].h >> 13);
    end

    assign in_ready  = adv[0];
    assign out_valid = valid_reg[STG-1];
    assign out_data  = s_reg[STG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STG; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s_reg[0].qp    <= in_data.qp;
            s_reg[0].gsize <= in_data.gsize;
            s_reg[0].h     <= x0 * ehns_pkg::MH_F1;
        end
        if (adv[1])
        begin
            s_reg[1].qp    <= s_reg[0].qp;
            s_reg[1].gsize <= s_reg[0].gsize;
            s_reg[1].h     <= x1 * ehns_pkg::MH_F2;
        end
        if (adv[2])
        begin
            s_reg[2].qp    <= s_reg[1].qp;
            s_reg[2].gsize <= s_reg[1].gsize;
            s_reg[2].h     <= s_reg[1].h ^ (s_reg[1].h >> 16);
        end
    end

endmodule

### hw/rtl/ehns_mod.sv
// pipelined restoring remainder of the hash by the clamped group size,
// eight hash bits per stage; uses ehns_pkg

module ehns_mod #(
    parameter int MAX_NEXT_HOPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ehns_pkg::hash_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output ehns_pkg::res_t  out_data
);

    localparam int SAT_MAX = (MAX_NEXT_HOPS > 31) ? 31 : MAX_NEXT_HOPS;
    localparam int DIV_W   = (SAT_MAX < 2) ? 1 : $clog2(SAT_MAX + 1);
    localparam int STEP    = 8;
    localparam int STG     = ehns_pkg::HASH_W / STEP;

    typedef struct packed {
        logic [ehns_pkg::HASH_W-1:0] h;
        logic [DIV_W-1:0]            r;
        logic [DIV_W-1:0]            d;
        logic                        z;
    } rem_t;

    logic [STG-1:0]               valid_reg;
    logic [STG:0]                 adv;
    rem_t                         s_reg [STG];
    rem_t                         nxt   [STG];
    rem_t                         first;
    logic [ehns_pkg::GSIZE_W-1:0] gs_eff;

    always_comb
    begin
        adv[STG] = out_ready;
        for (int i = STG - 1; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    // clamp group size to the configured maximum
    always_comb
    begin
        gs_eff = (in_data.gsize > ehns_pkg::GSIZE_W'(SAT_MAX))
                 ? ehns_pkg::GSIZE_W'(SAT_MAX) : in_data.gsize;
        first.h = in_data.h;
        first.r = '0;
        first.d = DIV_W'(gs_eff);
        first.z = (gs_eff == '0);
    end

    always_comb
    begin
        rem_t             src;
        logic [DIV_W:0]   t;
        logic [DIV_W-1:0] r;
        for (int i = 0; i < STG; i++)
        begin
            src = (i == 0) ? first : s_reg[i-1];
            r   = src.r;
            for (int j = 0; j < STEP; j++)
            begin
                t = {r, src.h[ehns_pkg::HASH_W-1-i*STEP-j]};
                if (t >= {1'b0, src.d})
                begin
                    r = DIV_W'(t - {1'b0, src.d});
                end
                else
                begin
                    r = DIV_W'(t);
                end
            end
            nxt[i]   = src;
            nxt[i].r = r;
        end
    end

    assign in_ready                = adv[0];
    assign out_valid               = valid_reg[STG-1];
    assign out_data.hash_value     = s_reg[STG-1].h;
    assign out_data.member_index   = s_reg[STG-1].z ? '0
                                     : ehns_pkg::MEMBER_W'(s_reg[STG-1].r);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STG; i++)
            begin
                if (adv[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STG; i++)
        begin
            if (adv[i])
            begin
                s_reg[i] <= nxt[i];
            end
        end
    end

endmodule

### hw/rtl/ehns_chk.sv
// port-level checks for ecmp_hash_next_hop_select and the bind that attaches them
// depends on ehns_pkg and the top-level port list

module ehns_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ehns_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // no result can be pending while reset is held
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

    // a draining or empty output frees every stage, so input must be ready
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
        else $error("input stalled while output side is free");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped under backpressure");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed under backpressure");

endmodule

bind ecmp_hash_next_hop_select ehns_chk u_ehns_chk (.*);
